/* rtl/cpf_pkg.sv */
// Shared types and constants for the command packet framer.
// No dependencies; every other file in this block imports it.
package cpf_pkg;

  localparam logic [7:0] HEAD_HI   = 8'hEF;
  localparam logic [7:0] HEAD_LO   = 8'h01;
  localparam logic [7:0] LEN_EXTRA = 8'd3;
  localparam logic [31:0] ADDR_RESET = 32'hFFFF_FFFF;

  // Byte positions of a framed packet in transmit order.
  typedef enum logic [3:0] {
    S_HEAD_HI  = 4'd0,
    S_HEAD_LO  = 4'd1,
    S_ADDR_3   = 4'd2,
    S_ADDR_2   = 4'd3,
    S_ADDR_1   = 4'd4,
    S_ADDR_0   = 4'd5,
    S_FLAG     = 4'd6,
    S_LEN_HI   = 4'd7,
    S_LEN_LO   = 4'd8,
    S_CMD      = 4'd9,
    S_DATA     = 4'd10,
    S_SUM_HI   = 4'd11,
    S_SUM_LO   = 4'd12
  } cpf_step_t;

  // One classified input item, as handed from the front end to the back end.
  typedef struct packed {
    logic        hdr;     // emit the ten header bytes
    logic        dat;     // emit one data byte
    logic        chk;     // emit the two checksum bytes
    logic [7:0]  flag;
    logic [7:0]  cmd;
    logic [7:0]  len_hi;
    logic [7:0]  len_lo;
    logic [7:0]  data;
    logic [15:0] sum;     // checksum including this item's data byte
  } cpf_desc_t;

endpackage

/* rtl/command_packet_framer_core.sv */
// Command packet framer: turns command items into the framed byte stream of
// a serial sensor module. The first item of a packet carries the flag, the
// command and the payload count (saturated to MAX_PAYLOAD) and produces the
// header 0xEF 0x01, the four address bytes most significant first, the flag,
// the two-byte length (count + 3), the command and the first data byte if
// any; each later item produces one data byte, and the last data byte is
// followed by the 16-bit checksum, high byte first. One transfer on the
// output carries one byte; out_run_last marks the last byte of an input
// item and out_packet_end the closing checksum byte. The input takes one
// item per cycle while the descriptor queue (QUEUE_DEPTH entries) has room;
// the output sends one byte per cycle while out_stall is low; a data-only
// item produces one byte, or three if it closes the packet, and a packet
// start eleven to thirteen bytes. The output byte sequencer sets the
// sustained rate; the queue absorbs bursts. An accepted item reaches the
// output through the queue, sequencer load and output register. The
// device address register resets to all ones and is written over the cfg_
// channel, which is always ready; write it only while the framer is idle.
module command_packet_framer_core import cpf_pkg::*; #(
  parameter int MAX_PAYLOAD = 128,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_packet_flag,
  input  logic [7:0]  in_command,
  input  logic [7:0]  in_payload_count,
  input  logic [7:0]  in_data_byte,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_packet_end,
  output logic        out_run_last,
  // Configuration write channel (device address)
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [31:0] dev_addr_r;
  cpf_desc_t   q_wdata, q_rdata;
  logic        q_push, q_pop, q_full, q_empty;

  // The address register takes a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dev_addr_r <= cfg_data;
    end
  end

  // Front end: classifies each item and keeps the running checksum.
  cpf_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_packet_flag   (in_packet_flag),
    .in_command       (in_command),
    .in_payload_count (in_payload_count),
    .in_data_byte     (in_data_byte),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_wdata          (q_wdata)
  );

  // Descriptor queue decoupling the two ends.
  cpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Back end: byte sequencer and output register.
  cpf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .dev_addr       (dev_addr_r),
    .q_rdata        (q_rdata),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_packet_end (out_packet_end),
    .out_run_last   (out_run_last)
  );

  // The closing checksum byte is always the last byte of its input item.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_packet_end |-> out_run_last)
    else $error("packet end without run last");

  // The back end never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue underflow");

  // Reset leaves no transfer pending at the output.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

/* rtl/cpf_front.sv */
// Front end of the command packet framer: accepts input items, tracks the
// packet position and checksum, and turns each item into a descriptor.
// Depends on cpf_pkg.
module cpf_front import cpf_pkg::*; #(
  parameter int MAX_PAYLOAD = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_packet_flag,
  input  logic [7:0] in_command,
  input  logic [7:0] in_payload_count,
  input  logic [7:0] in_data_byte,
  input  logic       q_full,
  output logic       q_push,
  output cpf_desc_t  q_wdata
);

  localparam logic [7:0] MaxCount = 8'(MAX_PAYLOAD);

  logic        in_packet_r, in_packet_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [15:0] sum_r, sum_nxt;

  logic [7:0]  count_sat;
  logic [8:0]  len;
  logic [15:0] sum_base;
  logic [15:0] sum_data;
  logic [7:0]  left_base;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    count_sat = (in_payload_count > MaxCount) ? MaxCount : in_payload_count;
    len       = {1'b0, count_sat} + {1'b0, LEN_EXTRA};
    sum_base  = in_packet_r ? sum_r
              : ({8'd0, in_packet_flag} + {15'd0, len[8]} + {8'd0, len[7:0]}
                 + {8'd0, in_command});
    left_base = in_packet_r ? left_r : count_sat;
    sum_data  = sum_base + {8'd0, in_data_byte};

    q_wdata.hdr    = !in_packet_r;
    q_wdata.dat    = (left_base != 8'd0);
    q_wdata.flag   = in_packet_flag;
    q_wdata.cmd    = in_command;
    q_wdata.len_hi = {7'd0, len[8]};
    q_wdata.len_lo = len[7:0];
    q_wdata.data   = in_data_byte;

    if (left_base != 8'd0) begin
      left_nxt = left_base - 8'd1;
      sum_nxt  = sum_data;
    end else begin
      left_nxt = 8'd0;
      sum_nxt  = sum_base;
    end
    q_wdata.sum = sum_nxt;
    q_wdata.chk = (left_nxt == 8'd0);
    in_packet_nxt = (left_nxt != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r <= 1'b0;
      left_r      <= 8'd0;
      sum_r       <= 16'd0;
    end else if (q_push) begin
      in_packet_r <= in_packet_nxt;
      left_r      <= left_nxt;
      sum_r       <= in_packet_nxt ? sum_nxt : 16'd0;
    end
  end

endmodule

/* rtl/cpf_queue.sv */
// Small descriptor queue between the framer front and back ends.
// Depends on cpf_pkg for the descriptor type.
module cpf_queue import cpf_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cpf_desc_t wdata,
  output logic      full,
  input  logic      pop,
  output cpf_desc_t rdata,
  output logic      empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  cpf_desc_t       mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r, count_nxt;

  assign full  = (count_r == FullCnt);
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrW'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

/* rtl/cpf_back.sv */
// Back end of the command packet framer: walks each descriptor through its
// byte sequence and drives the registered output channel. Depends on cpf_pkg.
module cpf_back import cpf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] dev_addr,
  input  cpf_desc_t   q_rdata,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_packet_end,
  output logic        out_run_last
);

  cpf_desc_t cur_r;
  logic      busy_r;
  cpf_step_t step_r, step_nxt, step_follow, step_first;
  logic      is_last;
  logic      advance;
  logic      take;
  logic [7:0] byte_sel;

  logic       valid_r;
  logic [7:0] byte_r;
  logic       end_r;
  logic       last_r;

  assign advance = !valid_r || !out_stall;
  // A new descriptor is loaded when the sequencer is idle or the current one has sent its last byte.
  assign take    = advance && (!busy_r || is_last);
  assign q_pop   = take && !q_empty;

  // Next-state logic of the byte sequencer.
  always_comb begin
    step_follow = step_r;
    is_last     = 1'b0;
    case (step_r)
      S_CMD: begin
        if (cur_r.dat) begin
          step_follow = S_DATA;
        end else if (cur_r.chk) begin
          step_follow = S_SUM_HI;
        end else begin
          is_last = 1'b1;
        end
      end
      S_DATA: begin
        if (cur_r.chk) begin
          step_follow = S_SUM_HI;
        end else begin
          is_last = 1'b1;
        end
      end
      S_SUM_HI: step_follow = S_SUM_LO;
      S_SUM_LO: is_last = 1'b1;
      default:  step_follow = cpf_step_t'(step_r + 4'd1);
    endcase

    if (q_rdata.hdr) begin
      step_first = S_HEAD_HI;
    end else if (q_rdata.dat) begin
      step_first = S_DATA;
    end else begin
      step_first = S_SUM_HI;
    end

    step_nxt = take ? step_first : (advance ? step_follow : step_r);
  end

  // Output logic: the byte for the current position.
  always_comb begin
    case (step_r)
      S_HEAD_HI: byte_sel = HEAD_HI;
      S_HEAD_LO: byte_sel = HEAD_LO;
      S_ADDR_3:  byte_sel = dev_addr[31:24];
      S_ADDR_2:  byte_sel = dev_addr[23:16];
      S_ADDR_1:  byte_sel = dev_addr[15:8];
      S_ADDR_0:  byte_sel = dev_addr[7:0];
      S_FLAG:    byte_sel = cur_r.flag;
      S_LEN_HI:  byte_sel = cur_r.len_hi;
      S_LEN_LO:  byte_sel = cur_r.len_lo;
      S_CMD:     byte_sel = cur_r.cmd;
      S_DATA:    byte_sel = cur_r.data;
      S_SUM_HI:  byte_sel = cur_r.sum[15:8];
      S_SUM_LO:  byte_sel = cur_r.sum[7:0];
      default:   byte_sel = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_rdata;
    end
    if (advance) begin
      byte_r <= byte_sel;
      end_r  <= (step_r == S_SUM_LO);
      last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      step_r  <= S_HEAD_HI;
      valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (take) begin
        busy_r <= !q_empty;
      end
      if (advance) begin
        valid_r <= busy_r;
      end
    end
  end

  assign out_valid      = valid_r;
  assign out_byte       = byte_r;
  assign out_packet_end = end_r;
  assign out_run_last   = last_r;

endmodule
